FILE: hw/rtl/tpce_pkg.sv
package tpce_pkg;

  localparam int unsigned NumConnectionsDefault = 8;
  localparam logic [15:0] ListenPortReset = 16'd80;
  localparam logic [15:0] ReceiveWindowReset = 16'd8192;
  localparam int unsigned CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] CfgListenPort = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgReceiveWindow = 1'b1;

  localparam logic [1:0] OpSegment = 2'd0;
  localparam logic [1:0] OpSendData = 2'd1;
  localparam logic [1:0] OpSendFin = 2'd2;

  localparam logic [2:0] StClosed = 3'd0;
  localparam logic [2:0] StSynRcvd = 3'd1;
  localparam logic [2:0] StEstablished = 3'd2;
  localparam logic [2:0] StCloseWait = 3'd3;
  localparam logic [2:0] StLastAck = 3'd4;

  localparam logic [7:0] FlagFin = 8'h01;
  localparam logic [7:0] FlagSyn = 8'h02;
  localparam logic [7:0] FlagRst = 8'h04;
  localparam logic [7:0] FlagPsh = 8'h08;
  localparam logic [7:0] FlagAck = 8'h10;

  localparam logic [15:0] MinSegmentLen = 16'd20;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] lport;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  flags;
    logic [3:0]  header_words;
    logic [15:0] segment_len;
    logic        checksum_ok;
  } req_t;

  typedef struct packed {
    logic        send_segment;
    logic        deliver;
    logic [31:0] out_peer_ip;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [7:0]  out_flags;
    logic [15:0] out_window;
    logic [5:0]  payload_offset;
    logic [15:0] data_len;
  } rsp_t;

  typedef struct packed {
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] lport;
    logic [31:0] send_next;
    logic [31:0] recv_next;
  } conn_t;

endpackage

FILE: hw/rtl/tpce_if.sv
interface tpce_req_if;
  import tpce_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tpce_rsp_if;
  import tpce_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/tcp_passive_connection_engine_top.sv
// Server-side TCP connection engine. Each request (received segment, send data or send FIN)
// gives exactly one response. Connection blocks sit in a synchronous memory; the state codes
// and peer address tags sit in flip-flops so that lookup and free-entry search are a single
// parallel compare. A request passes through accept, lookup plus memory read, decide with
// write back and registering of the response, and a turnaround state before the next accept;
// the read-modify-write of the memory sets this order. The next request is accepted while the
// response waits in the output register; a request whose response finds that register still
// full holds in its decide step, and the input stalls behind it.
module tcp_passive_connection_engine_top #(
  parameter int unsigned NUM_CONNECTIONS = tpce_pkg::NumConnectionsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tpce_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [15:0]                    cfg_data_i,
  tpce_req_if.sink                       req,
  tpce_rsp_if.source                     rsp
);
  import tpce_pkg::*;

  localparam int unsigned IdxW = (NUM_CONNECTIONS > 1) ? $clog2(NUM_CONNECTIONS) : 1;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SRead = 2'd1;
  localparam logic [1:0] SExec = 2'd2;
  localparam logic [1:0] SOut = 2'd3;

  logic [15:0] listen_port_q, receive_window_q;
  logic [1:0] fsm_q, fsm_d;
  req_t req_q;
  logic [2:0] st_q [NUM_CONNECTIONS];
  conn_t mem [NUM_CONNECTIONS];
  conn_t rd_q;
  logic hit_q, free_ok_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  rsp_t rsp_q, rsp_d;
  logic rsp_valid_q;
  logic exec_go;

  logic hit_d, free_ok_d;
  logic [IdxW-1:0] hit_idx_d, free_idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_port_q <= ListenPortReset;
      receive_window_q <= ReceiveWindowReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgListenPort) listen_port_q <= cfg_data_i;
      else listen_port_q <= listen_port_q;
      if (cfg_idx_i == CfgReceiveWindow) receive_window_q <= cfg_data_i;
    end
  end

  // Lookup compares peer fields of every entry; peer fields live in flip-flop copies too.
  logic [31:0] tag_ip [NUM_CONNECTIONS];
  logic [15:0] tag_port [NUM_CONNECTIONS];

  always_comb begin
    hit_d = 1'b0;
    hit_idx_d = '0;
    free_ok_d = 1'b0;
    free_idx_d = '0;
    for (int i = NUM_CONNECTIONS - 1; i >= 0; i--) begin
      if (st_q[i] != StClosed && tag_ip[i] == req_q.peer_ip &&
          tag_port[i] == req_q.peer_port) begin
        hit_d = 1'b1;
        hit_idx_d = IdxW'(i);
      end
      if (st_q[i] == StClosed) begin
        free_ok_d = 1'b1;
        free_idx_d = IdxW'(i);
      end
    end
  end

  assign exec_go = (fsm_q == SExec) && (!rsp_valid_q || rsp.ready);
  assign req.ready = (fsm_q == SIdle);
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload = rsp_q;

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) req_q <= req.payload;
    if (fsm_q == SRead) begin
      rd_q <= mem[hit_idx_d];
      hit_idx_q <= hit_idx_d;
      free_idx_q <= free_idx_d;
    end
  end

  // Decision logic.
  logic [2:0] cur_st;
  logic [31:0] plen;
  logic [15:0] hlen;
  logic wr_en;
  logic [IdxW-1:0] wr_idx;
  conn_t wr_data;
  logic [2:0] wr_st;
  logic st_en;

  always_comb begin
    cur_st = st_q[hit_idx_q];
    hlen = {10'd0, req_q.header_words, 2'b00};
    plen = {16'd0, req_q.segment_len - hlen};
    rsp_d = '0;
    wr_en = 1'b0;
    st_en = 1'b0;
    wr_idx = hit_idx_q;
    wr_data = rd_q;
    wr_st = cur_st;
    unique case (req_q.op)
      OpSegment: begin
        if (req_q.segment_len >= MinSegmentLen && req_q.segment_len >= hlen &&
            req_q.checksum_ok) begin
          if ((req_q.flags & FlagSyn) != 8'd0 && (req_q.flags & FlagAck) == 8'd0 &&
              !hit_q && req_q.lport == listen_port_q) begin
            if (free_ok_q) begin
              wr_en = 1'b1;
              st_en = 1'b1;
              wr_idx = free_idx_q;
              wr_st = StSynRcvd;
              wr_data.peer_ip = req_q.peer_ip;
              wr_data.peer_port = req_q.peer_port;
              wr_data.lport = req_q.lport;
              wr_data.send_next = 32'd1;
              wr_data.recv_next = req_q.seq_num + 32'd1;
              rsp_d.send_segment = 1'b1;
              rsp_d.out_peer_ip = req_q.peer_ip;
              rsp_d.out_src_port = req_q.lport;
              rsp_d.out_dst_port = req_q.peer_port;
              rsp_d.out_ack = req_q.seq_num + 32'd1;
              rsp_d.out_flags = FlagSyn | FlagAck;
              rsp_d.out_window = receive_window_q;
            end
          end else if (hit_q) begin
            if (cur_st == StSynRcvd && (req_q.flags & FlagAck) != 8'd0 &&
                (req_q.flags & FlagSyn) == 8'd0 && req_q.ack_num == rd_q.send_next) begin
              st_en = 1'b1;
              wr_st = StEstablished;
            end else if (cur_st == StEstablished && plen != 32'd0) begin
              if (req_q.seq_num == rd_q.recv_next) begin
                wr_en = 1'b1;
                wr_data.recv_next = rd_q.recv_next + plen;
                rsp_d.send_segment = 1'b1;
                rsp_d.deliver = 1'b1;
                rsp_d.out_peer_ip = req_q.peer_ip;
                rsp_d.out_src_port = rd_q.lport;
                rsp_d.out_dst_port = rd_q.peer_port;
                rsp_d.out_seq = rd_q.send_next;
                rsp_d.out_ack = rd_q.recv_next + plen;
                rsp_d.out_flags = FlagAck;
                rsp_d.out_window = receive_window_q;
                rsp_d.payload_offset = hlen[5:0];
                rsp_d.data_len = plen[15:0];
              end
            end else if ((req_q.flags & FlagFin) != 8'd0 && cur_st == StEstablished) begin
              wr_en = 1'b1;
              st_en = 1'b1;
              wr_st = StCloseWait;
              wr_data.recv_next = rd_q.recv_next + 32'd1;
              rsp_d.send_segment = 1'b1;
              rsp_d.out_peer_ip = req_q.peer_ip;
              rsp_d.out_src_port = rd_q.lport;
              rsp_d.out_dst_port = rd_q.peer_port;
              rsp_d.out_seq = rd_q.send_next;
              rsp_d.out_ack = rd_q.recv_next + 32'd1;
              rsp_d.out_flags = FlagAck;
              rsp_d.out_window = receive_window_q;
            end else if ((req_q.flags & FlagRst) != 8'd0) begin
              st_en = 1'b1;
              wr_st = StClosed;
            end
          end
        end
      end
      OpSendData, OpSendFin: begin
        if (hit_q && cur_st == StEstablished) begin
          wr_en = 1'b1;
          rsp_d.send_segment = 1'b1;
          rsp_d.out_peer_ip = req_q.peer_ip;
          rsp_d.out_src_port = req_q.lport;
          rsp_d.out_dst_port = req_q.peer_port;
          rsp_d.out_seq = rd_q.send_next;
          rsp_d.out_ack = rd_q.recv_next;
          rsp_d.out_window = receive_window_q;
          if (req_q.op == OpSendFin) begin
            st_en = 1'b1;
            wr_st = StLastAck;
            rsp_d.out_flags = FlagFin | FlagAck;
            wr_data.send_next = rd_q.send_next + 32'd1;
          end else begin
            rsp_d.out_flags = FlagAck | FlagPsh;
            wr_data.send_next = rd_q.send_next + {16'd0, req_q.segment_len};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (exec_go && wr_en) begin
      mem[wr_idx] <= wr_data;
      tag_ip[wr_idx] <= wr_data.peer_ip;
      tag_port[wr_idx] <= wr_data.peer_port;
    end
    if (exec_go) rsp_q <= rsp_d;
  end

  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      SIdle: if (req.valid && req.ready) fsm_d = SRead;
      SRead: fsm_d = SExec;
      SExec: if (exec_go) fsm_d = SOut;
      SOut: fsm_d = SIdle;
      default: fsm_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= SIdle;
      rsp_valid_q <= 1'b0;
      hit_q <= 1'b0;
      free_ok_q <= 1'b0;
      for (int i = 0; i < NUM_CONNECTIONS; i++) st_q[i] <= StClosed;
    end else begin
      fsm_q <= fsm_d;
      if (fsm_q == SRead) begin
        hit_q <= hit_d;
        free_ok_q <= free_ok_d;
      end
      if (exec_go && st_en) st_q[wr_idx] <= wr_st;
      if (exec_go) rsp_valid_q <= 1'b1;
      else if (rsp.ready) rsp_valid_q <= 1'b0;
    end
  end

endmodule
